>>> hdl/positional_list_engine_core_defines.svh
// Assertion helpers for the list engine core.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define PLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 16;

    // Field widths
    localparam int ACT_W   = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 8;
    localparam int CNT_O_W = 8;
    localparam int ST_W    = 3;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_FIELDS_W = ACT_W + VAL_W + POS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + VAL_W + POS_W + CNT_O_W + 1 + ST_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH      = 3'd0,
        ACT_INSERT_AT = 3'd1,
        ACT_DELETE_AT = 3'd2,
        ACT_DELETE_VAL= 3'd3,
        ACT_SEARCH    = 3'd4,
        ACT_DEQUEUE   = 3'd5
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

endpackage

`default_nettype wire

>>> hdl/ple_store.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_store #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [ple_pkg::VAL_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [ple_pkg::VAL_W-1:0] o_rdata
);
    import ple_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/positional_list_engine_core.sv
// Push and insert move the entries from the tail back to the gap; delete and dequeue close
// the gap from the removed slot to the tail; search and delete value walk from the front
// to the first match. A rejected transaction goes straight to the result with no walk.
// Each walk goes through the entry store one entry per cycle.
// Throughput: one transaction in flight; the next is accepted once the result is loaded.
// Reset: synchronous, active low; clears count, sequencer and output valid, not the store.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_core_defines.svh"

module positional_list_engine_core #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // action [2:0], item_value [34:3], slot_position [42:35], zero fill above
    input  wire logic [ple_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // ok [0], value_out [32:1], found_position [40:33], entry_count [48:41],
    // is_empty [49], status [52:50], zero fill above
    output logic      [ple_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ple_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_UP, S_PUT, S_DOWN, S_FIN, S_SCAN, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        P_NONE, P_WRITE, P_CAPTURE, P_COMPARE
    } t_pend;

    t_state           r_state;
    t_pend            r_pend;
    logic [AW-1:0]    r_pend_addr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_ptr;
    logic [AW-1:0]    r_idx;
    logic             r_all;
    t_action          r_act;
    logic [VAL_W-1:0] r_val;
    logic             r_ok;
    logic [VAL_W-1:0] r_vout;
    logic [POS_W-1:0] r_fpos;
    t_status          r_status;
    logic             r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    logic [ACT_W-1:0] in_act;
    logic [VAL_W-1:0] in_val;
    logic [POS_W-1:0] in_pos;
    logic             in_accept;
    logic             is_full;
    logic             is_zero;
    logic [AW-1:0]    last_idx;
    logic             match;
    logic             scan_issue;
    logic             up_issue;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;
    logic             out_free;

    // Unpack the input transaction
    assign in_act    = s_axis_tdata[ACT_W-1:0];
    assign in_val    = s_axis_tdata[ACT_W+VAL_W-1:ACT_W];
    assign in_pos    = s_axis_tdata[ACT_W+VAL_W+POS_W-1:ACT_W+VAL_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign is_full       = (r_count >= CW'(DEPTH));
    assign is_zero       = (r_count == '0);
    assign last_idx      = AW'(r_count - CW'(1));

    // Shared comparator on the store's read data
    assign match      = (r_pend == P_COMPARE) && (mem_rdata == r_val);
    assign scan_issue = (r_state == S_SCAN) && !match && !r_all;
    assign up_issue   = (r_state == S_UP) && (r_ptr != r_idx);
    assign out_free   = !r_m_tvalid || m_axis_tready;

    // Store port control: pending moves take the write port before a put
    always_comb begin
        mem_we    = (r_pend == P_WRITE) || (r_state == S_PUT);
        mem_waddr = (r_pend == P_WRITE) ? r_pend_addr : r_idx;
        mem_wdata = (r_pend == P_WRITE) ? mem_rdata : r_val;
        mem_re    = up_issue || scan_issue || (r_state == S_DOWN);
        mem_raddr = up_issue ? (r_ptr - AW'(1)) : r_ptr;
    end

    ple_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend     <= P_NONE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            // Release the output once taken
            if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end

            // Default: pending move lasts one cycle
            r_pend <= P_NONE;
            if (r_pend == P_CAPTURE) begin
                r_vout <= mem_rdata;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_act    <= t_action'(in_act);
                        r_val    <= in_val;
                        r_ok     <= 1'b0;
                        r_vout   <= '0;
                        r_fpos   <= '0;
                        r_status <= ST_OK;
                        r_all    <= 1'b0;
                        r_state  <= S_RESP;
                        case (in_act)
                            ACT_PUSH: begin
                                if (is_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_idx   <= '0;
                                    r_ptr   <= AW'(r_count);
                                    r_state <= S_UP;
                                end
                            end
                            ACT_INSERT_AT: begin
                                if (in_pos == '0 ||
                                    {1'b0, in_pos} > (9'(r_count) + 9'd1)) begin
                                    r_status <= ST_BADPOS;
                                end else if (is_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_idx   <= AW'(in_pos - 8'd1);
                                    r_ptr   <= AW'(r_count);
                                    r_state <= S_UP;
                                end
                            end
                            ACT_DELETE_AT: begin
                                if (is_zero) begin
                                    r_status <= ST_EMPTY;
                                end else if (in_pos == '0 || 9'(in_pos) > 9'(r_count)) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_idx   <= AW'(in_pos - 8'd1);
                                    r_ptr   <= AW'(in_pos - 8'd1);
                                    r_state <= S_DOWN;
                                end
                            end
                            ACT_DELETE_VAL, ACT_SEARCH: begin
                                if (is_zero) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_ptr   <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            ACT_DEQUEUE: begin
                                if (is_zero) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_idx   <= last_idx;
                                    r_ptr   <= last_idx;
                                    r_state <= S_DOWN;
                                end
                            end
                            default: begin
                                r_status <= ST_BADPOS;
                            end
                        endcase
                    end
                end

                // Move entries one place back, from the tail to the gap
                S_UP: begin
                    if (up_issue) begin
                        r_pend      <= P_WRITE;
                        r_pend_addr <= r_ptr;
                        r_ptr       <= r_ptr - AW'(1);
                    end else begin
                        r_state <= S_PUT;
                    end
                end

                // Drop the new value into the gap
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_ok    <= 1'b1;
                    r_state <= S_RESP;
                end

                // Capture the removed entry, then close the gap
                S_DOWN: begin
                    if (r_ptr == r_idx) begin
                        r_pend <= P_CAPTURE;
                    end else begin
                        r_pend <= P_WRITE;
                    end
                    r_pend_addr <= r_ptr - AW'(1);
                    if (r_ptr == last_idx) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end

                // Let the last move land
                S_FIN: begin
                    r_count <= r_count - CW'(1);
                    r_ok    <= 1'b1;
                    r_state <= S_RESP;
                end

                // Walk the list from the front for the first match
                S_SCAN: begin
                    if (match) begin
                        if (r_act == ACT_SEARCH) begin
                            r_ok    <= 1'b1;
                            r_fpos  <= POS_W'(r_pend_addr) + POS_W'(1);
                            r_state <= S_RESP;
                        end else begin
                            r_idx   <= r_pend_addr;
                            r_ptr   <= r_pend_addr;
                            r_state <= S_DOWN;
                        end
                    end else if (r_all) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_RESP;
                    end else begin
                        r_pend      <= P_COMPARE;
                        r_pend_addr <= r_ptr;
                        if (r_ptr == last_idx) begin
                            r_all <= 1'b1;
                        end else begin
                            r_ptr <= r_ptr + AW'(1);
                        end
                    end
                end

                // Hand the result to the output register
                S_RESP: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= M_TDATA_W'({r_status, is_zero,
                                                  CNT_O_W'(r_count), r_fpos, r_vout, r_ok});
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    // Checks
    `PLE_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH),
        "entry count above capacity")
    `PLE_ASSERT_NEXT(a_count_only_at_end, i_clk, i_rst_n,
        r_state != S_PUT && r_state != S_FIN, $stable(r_count),
        "entry count changed outside a completing insert or delete")
    `PLE_ASSERT_NOW(a_ok_matches_status, i_clk, i_rst_n, r_state == S_RESP,
        r_ok == (r_status == ST_OK), "ok flag disagrees with status")
    `PLE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !s_axis_tready,
        "input ready straight after an accepted transaction")

endmodule

`default_nettype wire

>>> tb/tb_positional_list_engine_core.sv
`timescale 1ns / 1ps

module tb_positional_list_engine_core;

    import ple_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEF;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int DRAIN_CYCLES   = 60;

    // Codes the block does not define; it must reject them
    localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

    typedef struct {
        logic             ok;
        logic [VAL_W-1:0] value_out;
        logic [POS_W-1:0] found_position;
        logic [7:0]       entry_count;
        logic             is_empty;
        t_status          status;
    } t_list_reply;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // action [2:0], item_value [34:3], slot_position [42:35], zero fill above
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // ok [0], value_out [32:1], found_position [40:33], entry_count [48:41],
    // is_empty [49], status [52:50], zero fill above
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Shadow of the list contents, position 1 at index 0
    logic [VAL_W-1:0] shadow_list[$];
    t_list_reply      pending_replies[$];

    int  error_count;
    int  quiet_cycles;
    bit  src_gaps_en;
    bit  sink_stalls_en;
    bit  hold_off_req;

    positional_list_engine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow list and return the reply it should give
    function automatic t_list_reply apply_list_op(logic [ACT_W-1:0] act,
                                                  logic [VAL_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
        t_list_reply r;
        int          cnt;
        int          hit;
        cnt              = shadow_list.size();
        hit              = -1;
        r.ok             = 1'b0;
        r.value_out      = '0;
        r.found_position = '0;
        r.status         = ST_OK;
        if (act == ACT_DELETE_VAL || act == ACT_SEARCH) begin
            for (int k = 0; k < cnt; k++) begin
                if (hit < 0 && shadow_list[k] == val) hit = k;
            end
        end
        case (act)
            ACT_PUSH: begin
                if (cnt >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_list.push_front(val);
                    r.ok = 1'b1;
                end
            end
            ACT_INSERT_AT: begin
                if (pos == 0 || pos > cnt + 1) begin
                    r.status = ST_BADPOS;
                end else if (cnt >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_list.insert(pos - 1, val);
                    r.ok = 1'b1;
                end
            end
            ACT_DELETE_AT: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos == 0 || pos > cnt) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.value_out = shadow_list[pos - 1];
                    shadow_list.delete(pos - 1);
                    r.ok = 1'b1;
                end
            end
            ACT_DELETE_VAL: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.value_out = shadow_list[hit];
                    shadow_list.delete(hit);
                    r.ok = 1'b1;
                end
            end
            ACT_SEARCH: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.found_position = POS_W'(hit + 1);
                    r.ok = 1'b1;
                end
            end
            ACT_DEQUEUE: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value_out = shadow_list.pop_back();
                    r.ok = 1'b1;
                end
            end
            default: begin
                r.status = ST_BADPOS;
            end
        endcase
        r.entry_count = 8'(shadow_list.size());
        r.is_empty    = (shadow_list.size() == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Offer one transaction, with an optional gap before it, and hold until accepted
    task automatic send_op(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
        if (src_gaps_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, pos, val, act};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_replies.push_back(apply_list_op(act, val, pos));
    endtask

    function automatic logic [ACT_W-1:0] draw_action(int grow_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
        if (r < 3 + grow_pct) return $urandom_range(0, 1) ? ACT_PUSH : ACT_INSERT_AT;
        case ($urandom_range(0, 3))
            0:       return ACT_DELETE_AT;
            1:       return ACT_DELETE_VAL;
            2:       return ACT_SEARCH;
            default: return ACT_DEQUEUE;
        endcase
    endfunction

    // Mostly a legal slot, sometimes zero, one past the last legal slot, or anything
    function automatic logic [POS_W-1:0] draw_position(logic [ACT_W-1:0] act);
        int top;
        int r;
        top = shadow_list.size() + ((act == ACT_INSERT_AT) ? 1 : 0);
        r   = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 8'd255;
        if (r == 2) return POS_W'($urandom_range(0, 255));
        if (r == 3) return POS_W'(top + 1);
        if (top == 0) return 8'd1;
        return POS_W'($urandom_range(1, top));
    endfunction

    // Lookups mostly hit a stored value; small values give duplicates
    function automatic logic [VAL_W-1:0] draw_value(logic [ACT_W-1:0] act);
        int r;
        r = $urandom_range(0, 9);
        if ((act == ACT_DELETE_VAL || act == ACT_SEARCH) && shadow_list.size() > 0 && r < 7)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        if (r < 3) return $urandom_range(0, 7);
        if (r == 3) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic test_empty_list;
        send_op(ACT_DELETE_AT, 32'd1, 8'd1);
        send_op(ACT_DELETE_VAL, 32'd0, 8'd0);
        send_op(ACT_SEARCH, 32'd0, 8'd0);
        send_op(ACT_DEQUEUE, 32'd0, 8'd0);
        send_op(ACT_INSERT_AT, 32'd9, 8'd0);
        send_op(ACT_INSERT_AT, 32'd9, 8'd2);
        send_op(ACT_UNUSED_7, 32'hFFFF_FFFF, 8'd255);
    endtask

    task automatic test_list_ops;
        send_op(ACT_PUSH, 32'h7FFF_FFFF, 8'd0);
        send_op(ACT_PUSH, 32'h8000_0000, 8'd0);
        send_op(ACT_INSERT_AT, 32'd5, 8'd3);
        send_op(ACT_INSERT_AT, 32'd0, 8'd1);
        send_op(ACT_INSERT_AT, 32'd6, 8'd6);
        send_op(ACT_SEARCH, 32'd5, 8'd0);
        send_op(ACT_SEARCH, 32'd123, 8'd0);
        send_op(ACT_DELETE_VAL, 32'd77, 8'd0);
        send_op(ACT_DELETE_AT, 32'd0, 8'd0);
        send_op(ACT_DELETE_AT, 32'd0, 8'd5);
        send_op(ACT_UNUSED_6, 32'd0, 8'd1);
        // duplicate: search and delete must take the first match
        send_op(ACT_PUSH, 32'd5, 8'd0);
        send_op(ACT_SEARCH, 32'd5, 8'd0);
        send_op(ACT_DELETE_VAL, 32'd5, 8'd0);
        send_op(ACT_DELETE_AT, 32'd0, 8'd2);
        send_op(ACT_DEQUEUE, 32'd0, 8'd0);
    endtask

    task automatic test_full_list;
        while (shadow_list.size() < LIST_DEPTH) send_op(ACT_PUSH, $urandom, 8'd0);
        send_op(ACT_PUSH, 32'd1, 8'd0);
        send_op(ACT_INSERT_AT, 32'd1, 8'd1);
        // position check wins over the full check
        send_op(ACT_INSERT_AT, 32'd1, 8'd255);
        send_op(ACT_DELETE_AT, 32'd0, 8'd16);
        send_op(ACT_INSERT_AT, 32'hA5A5_5A5A, 8'd16);
    endtask

    task automatic test_random_mix(input int n_items, input int grow_pct);
        logic [ACT_W-1:0] act;
        for (int i = 0; i < n_items; i++) begin
            act = draw_action(grow_pct);
            send_op(act, draw_value(act), draw_position(act));
        end
    endtask

    // Stall the reply side while input keeps coming, so the block backs up
    task automatic test_output_backpressure;
        src_gaps_en  = 1'b0;
        hold_off_req = 1'b1;
        test_random_mix(8, 50);
        src_gaps_en  = 1'b1;
    endtask

    // Reply sink: random stall bursts plus one long hold-off on request
    initial begin
        bit hold_off_done;
        hold_off_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_LEN - 1) @(posedge i_clk);
            end else if (sink_stalls_en && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each reply transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_list_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("reply 0x%0h with none expected", m_axis_tdata));
            end else begin
                want = pending_replies.pop_front();
                check_field("ok", VAL_W'(m_axis_tdata[0]), VAL_W'(want.ok));
                check_field("value_out", m_axis_tdata[32:1], want.value_out);
                check_field("found_position", VAL_W'(m_axis_tdata[40:33]),
                            VAL_W'(want.found_position));
                check_field("entry_count", VAL_W'(m_axis_tdata[48:41]),
                            VAL_W'(want.entry_count));
                check_field("is_empty", VAL_W'(m_axis_tdata[49]), VAL_W'(want.is_empty));
                check_field("status", VAL_W'(m_axis_tdata[52:50]), VAL_W'(want.status));
            end
        end
    end

    // Abort if no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_positional_list_engine_core: FAIL");
            $finish;
        end
    end

    initial begin
        error_count    = 0;
        hold_off_req   = 1'b0;
        src_gaps_en    = 1'b1;
        sink_stalls_en = 1'b1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_list_ops();
        test_full_list();
        test_random_mix(135, 60);
        test_random_mix(135, 25);
        test_output_backpressure();

        // last stretch runs flat out on both sides
        src_gaps_en    = 1'b0;
        sink_stalls_en = 1'b0;
        test_random_mix(135, 45);
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));

        if (error_count == 0)
            $display("tb_positional_list_engine_core: PASS");
        else
            $display("tb_positional_list_engine_core: FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_store.sv
hdl/positional_list_engine_core.sv
tb/tb_positional_list_engine_core.sv
